// ===== src/gdfs_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the graph search unit.
package gdfs_pkg;

   localparam int DEF_MAX_VERTICES = 32;
   localparam int DEF_MAX_NODES    = 128;

   localparam int VERTEX_W   = 5;
   localparam int COUNT_W    = 6;
   localparam int REQ_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 3;

   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_EDGE   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_START = 2'd2;

   localparam logic [1:0] HEAD_SEL_REQ = 2'd0;
   localparam logic [1:0] HEAD_SEL_DST = 2'd1;
   localparam logic [1:0] HEAD_SEL_W   = 2'd2;

   // register index is paddr[2]
   localparam logic REG_NUM_VERTICES = 1'b0;
   localparam logic [COUNT_W-1:0] NUM_VERTICES_RESET = 6'd32;

   typedef struct packed {
      logic       clear_graph;
      logic       set_overflow;
      logic       latch_req;
      logic       start_search;
      logic       head_rd;
      logic [1:0] head_sel;
      logic       head_wr;
      logic       node_wr;
      logic       node_vert_src;
      logic       node_rd;
      logic       load_cur_head;
      logic       load_cur_next;
      logic       load_cur_stack;
      logic       stack_rd;
      logic       push;
      logic       visit;
      logic       out_pend;
      logic       out_last;
      logic       out_error;
   } gdfs_cmd_type;

   typedef struct packed {
      logic edge_ok;
      logic start_ok;
      logic cur_zero;
      logic sp_zero;
      logic w_new;
      logic can_push;
      logic out_free;
   } gdfs_sts_type;

endpackage

// ===== src/gdfs_csr.sv =====
// APB-style configuration register holding the vertex count.
module gdfs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [gdfs_pkg::APB_ADDR_W-1:0]    paddr,
   input  logic [gdfs_pkg::APB_DATA_W-1:0]    pwdata,
   output logic [gdfs_pkg::APB_DATA_W-1:0]    prdata,
   output logic                               pready,
   output logic [gdfs_pkg::COUNT_W-1:0]       num_vertices
);
   import gdfs_pkg::*;

   logic [COUNT_W-1:0] num_vertices_ff;
   logic [COUNT_W-1:0] num_vertices_in;
   logic               wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_NUM_VERTICES);

   always_comb begin
      num_vertices_in = num_vertices_ff;
      if (wr_hit) begin
         num_vertices_in = pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vertices_ff <= NUM_VERTICES_RESET;
      end else begin
         num_vertices_ff <= num_vertices_in;
      end
   end

   assign prdata = (paddr[2] == REG_NUM_VERTICES) ? APB_DATA_W'(num_vertices_ff)
                                                  : '0;
   assign num_vertices = num_vertices_ff;

endmodule

// ===== src/gdfs_dp.sv =====
// Datapath: list heads, node store, walk stack, visited marks and result register.
module gdfs_dp #(
   parameter int MAX_VERTICES = gdfs_pkg::DEF_MAX_VERTICES,
   parameter int MAX_NODES    = gdfs_pkg::DEF_MAX_NODES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gdfs_pkg::gdfs_cmd_type           cmd,
   output gdfs_pkg::gdfs_sts_type           sts,
   input  logic [gdfs_pkg::COUNT_W-1:0]     num_vertices,
   input  logic [gdfs_pkg::VERTEX_W-1:0]    req_src_vertex,
   input  logic [gdfs_pkg::VERTEX_W-1:0]    req_dest_vertex,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic [gdfs_pkg::VERTEX_W-1:0]    rsp_visited_vertex,
   output logic                             rsp_last,
   output logic [gdfs_pkg::STATUS_W-1:0]    rsp_status
);
   import gdfs_pkg::*;

   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int NW    = $clog2(MAX_NODES);
   localparam int LW    = $clog2(MAX_NODES + 1);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int ENT_W = VERTEX_W + LW;

   // memories
   logic [LW-1:0]    head_mem_ff  [MAX_VERTICES];
   logic [ENT_W-1:0] node_mem_ff  [MAX_NODES];
   logic [LW-1:0]    stack_mem_ff [MAX_VERTICES];

   logic [MAX_VERTICES-1:0] head_valid_ff, head_valid_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [LW-1:0]           head_rdata_ff;
   logic                    head_rvalid_ff;
   logic [VW-1:0]           head_waddr_ff;
   logic [ENT_W-1:0]        node_rdata_ff;
   logic [LW-1:0]           stack_rdata_ff;

   logic [LW-1:0]           nu_ff, nu_in;
   logic                    overflow_ff, overflow_in;
   logic [VW-1:0]           sp_ff, sp_in;
   logic [LW-1:0]           cur_ff, cur_in;
   logic [VERTEX_W-1:0]     src_ff, src_in;
   logic [VERTEX_W-1:0]     dst_ff, dst_in;
   logic [VERTEX_W-1:0]     pend_ff, pend_in;
   logic [STATUS_W-1:0]     status_ff, status_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_W-1:0]     rsp_vertex_ff, rsp_vertex_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0]        vcount;
   logic [VW-1:0]           head_raddr;
   logic [LW-1:0]           head_link;
   logic [VERTEX_W-1:0]     node_vertex;
   logic [LW-1:0]           node_next;
   logic [VERTEX_W-1:0]     node_wvert;
   logic                    src_ok, dst_ok;

   assign vcount = (32'(num_vertices) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                      : CNT_W'(num_vertices);
   assign src_ok = 32'(req_src_vertex) < 32'(vcount);
   assign dst_ok = 32'(req_dest_vertex) < 32'(vcount);

   assign head_link   = head_rvalid_ff ? head_rdata_ff : '0;
   assign node_vertex = node_rdata_ff[LW +: VERTEX_W];
   assign node_next   = node_rdata_ff[LW-1:0];
   assign node_wvert  = cmd.node_vert_src ? src_ff : dst_ff;

   always_comb begin
      case (cmd.head_sel)
         HEAD_SEL_REQ: head_raddr = VW'(req_src_vertex);
         HEAD_SEL_DST: head_raddr = VW'(dst_ff);
         HEAD_SEL_W:   head_raddr = VW'(node_vertex);
         default:      head_raddr = VW'(req_src_vertex);
      endcase
   end

   // head list memory: write goes to the address of the preceding read
   always_ff @(posedge clock) begin
      if (cmd.head_rd) begin
         head_rdata_ff  <= head_mem_ff[head_raddr];
         head_rvalid_ff <= head_valid_ff[head_raddr];
         head_waddr_ff  <= head_raddr;
      end
      if (cmd.head_wr) begin
         head_mem_ff[head_waddr_ff] <= LW'(nu_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.node_wr) begin
         node_mem_ff[NW'(nu_ff)] <= {node_wvert, head_link};
      end
      if (cmd.node_rd) begin
         node_rdata_ff <= node_mem_ff[NW'(cur_ff - 1'b1)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem_ff[sp_ff] <= node_next;
      end
      if (cmd.stack_rd) begin
         stack_rdata_ff <= stack_mem_ff[sp_ff - 1'b1];
      end
   end

   always_comb begin
      head_valid_in = head_valid_ff;
      visited_in    = visited_ff;
      nu_in         = nu_ff;
      overflow_in   = overflow_ff;
      sp_in         = sp_ff;
      cur_in        = cur_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      pend_in       = pend_ff;
      status_in     = status_ff;

      if (cmd.clear_graph) begin
         head_valid_in = '0;
         nu_in         = '0;
         overflow_in   = 1'b0;
      end
      if (cmd.set_overflow) begin
         overflow_in = 1'b1;
      end
      if (cmd.head_wr) begin
         head_valid_in[head_waddr_ff] = 1'b1;
      end
      if (cmd.node_wr) begin
         nu_in = LW'(nu_ff + 1'b1);
      end
      if (cmd.latch_req) begin
         src_in = req_src_vertex;
         dst_in = req_dest_vertex;
      end
      if (cmd.start_search) begin
         visited_in                      = '0;
         visited_in[VW'(req_src_vertex)] = 1'b1;
         pend_in                         = req_src_vertex;
         sp_in                           = '0;
         status_in                       = overflow_ff ? STATUS_DROPPED : STATUS_OK;
      end
      if (cmd.visit) begin
         visited_in[VW'(node_vertex)] = 1'b1;
         pend_in                      = node_vertex;
      end
      if (cmd.push) begin
         sp_in = sp_ff + 1'b1;
      end else if (cmd.stack_rd) begin
         sp_in = sp_ff - 1'b1;
      end
      if (cmd.load_cur_head) begin
         cur_in = head_link;
      end else if (cmd.load_cur_next) begin
         cur_in = node_next;
      end else if (cmd.load_cur_stack) begin
         cur_in = stack_rdata_ff;
      end
   end

   // result register; loaded only when empty or being taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.out_error) begin
         rsp_valid_in  = 1'b1;
         rsp_vertex_in = '0;
         rsp_last_in   = 1'b1;
         rsp_status_in = STATUS_BAD_START;
      end else if (cmd.out_pend || cmd.out_last) begin
         rsp_valid_in  = 1'b1;
         rsp_vertex_in = pend_ff;
         rsp_last_in   = cmd.out_last;
         rsp_status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= '0;
         visited_ff    <= '0;
         nu_ff         <= '0;
         overflow_ff   <= 1'b0;
         sp_ff         <= '0;
         cur_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         visited_ff    <= visited_in;
         nu_ff         <= nu_in;
         overflow_ff   <= overflow_in;
         sp_ff         <= sp_in;
         cur_ff        <= cur_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      pend_ff       <= pend_in;
      status_ff     <= status_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      sts.edge_ok  = src_ok && dst_ok && ((32'(nu_ff) + 2) <= MAX_NODES);
      sts.start_ok = src_ok;
      sts.cur_zero = (cur_ff == '0);
      sts.sp_zero  = (sp_ff == '0);
      sts.w_new    = (32'(node_vertex) < MAX_VERTICES) && !visited_ff[VW'(node_vertex)];
      sts.can_push = (32'(sp_ff) + 1) < MAX_VERTICES;
      sts.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_visited_vertex = rsp_vertex_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_status         = rsp_status_ff;

`ifndef SYNTHESIS
   a_nodes_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(nu_ff) <= MAX_NODES)
      else $error("node store fill count beyond capacity");
`endif

endmodule

// ===== src/gdfs_ctrl.sv =====
// Controller state machine sequencing edge inserts and the depth first walk.
module gdfs_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [gdfs_pkg::REQ_W-1:0]    req_type,
   output logic                          req_stall,
   input  gdfs_pkg::gdfs_sts_type        sts,
   output gdfs_pkg::gdfs_cmd_type        cmd
);
   import gdfs_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_E_SRC    = 4'd1;
   localparam logic [3:0] ST_E_RD_DST = 4'd2;
   localparam logic [3:0] ST_E_DST    = 4'd3;
   localparam logic [3:0] ST_S_HEAD   = 4'd4;
   localparam logic [3:0] ST_S_STEP   = 4'd5;
   localparam logic [3:0] ST_S_NODE   = 4'd6;
   localparam logic [3:0] ST_S_POP    = 4'd7;
   localparam logic [3:0] ST_S_FLUSH  = 4'd8;
   localparam logic [3:0] ST_S_ERR    = 4'd9;

   logic [3:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               case (req_type)
                  REQ_CLEAR: begin
                     cmd.clear_graph = 1'b1;
                  end
                  REQ_EDGE: begin
                     if (sts.edge_ok) begin
                        cmd.head_rd  = 1'b1;
                        cmd.head_sel = HEAD_SEL_REQ;
                        state_in     = ST_E_SRC;
                     end else begin
                        cmd.set_overflow = 1'b1;
                     end
                  end
                  REQ_SEARCH: begin
                     if (sts.start_ok) begin
                        cmd.start_search = 1'b1;
                        cmd.head_rd      = 1'b1;
                        cmd.head_sel     = HEAD_SEL_REQ;
                        state_in         = ST_S_HEAD;
                     end else begin
                        state_in = ST_S_ERR;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // src list gets a node naming dst
         ST_E_SRC: begin
            cmd.node_wr = 1'b1;
            cmd.head_wr = 1'b1;
            state_in    = ST_E_RD_DST;
         end
         ST_E_RD_DST: begin
            cmd.head_rd  = 1'b1;
            cmd.head_sel = HEAD_SEL_DST;
            state_in     = ST_E_DST;
         end
         ST_E_DST: begin
            cmd.node_wr       = 1'b1;
            cmd.node_vert_src = 1'b1;
            cmd.head_wr       = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_S_HEAD: begin
            cmd.load_cur_head = 1'b1;
            state_in          = ST_S_STEP;
         end
         ST_S_STEP: begin
            if (!sts.cur_zero) begin
               cmd.node_rd = 1'b1;
               state_in    = ST_S_NODE;
            end else if (sts.sp_zero) begin
               state_in = ST_S_FLUSH;
            end else begin
               cmd.stack_rd = 1'b1;
               state_in     = ST_S_POP;
            end
         end
         // advance cursor; a new vertex pushes the previous one out and descends if the stack has room
         ST_S_NODE: begin
            cmd.load_cur_next = 1'b1;
            if (!sts.w_new) begin
               state_in = ST_S_STEP;
            end else if (sts.out_free) begin
               cmd.visit    = 1'b1;
               cmd.out_pend = 1'b1;
               if (sts.can_push) begin
                  cmd.push     = 1'b1;
                  cmd.head_rd  = 1'b1;
                  cmd.head_sel = HEAD_SEL_W;
                  state_in     = ST_S_HEAD;
               end else begin
                  state_in = ST_S_STEP;
               end
            end
         end
         ST_S_POP: begin
            cmd.load_cur_stack = 1'b1;
            state_in           = ST_S_STEP;
         end
         ST_S_FLUSH: begin
            if (sts.out_free) begin
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_S_ERR: begin
            if (sts.out_free) begin
               cmd.out_error = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_out_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_pend || cmd.out_last || cmd.out_error) |-> sts.out_free)
      else $error("result loaded while result register is held");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.out_pend, cmd.out_last, cmd.out_error}))
      else $error("more than one result load in a cycle");

   a_push_visit: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (sts.can_push && cmd.visit && cmd.head_rd))
      else $error("stack push without a new vertex visit");
`endif

endmodule

// ===== src/graph_depth_first_search_unit.sv =====
// Top level of the graph depth first search unit.
// Usage:
//   Request channel (req_*): req_type selects clear graph, add undirected edge or
//   search from req_src_vertex. A transaction completes when req_valid is high and
//   req_stall is low. Unused request codes are dropped.
//   Result channel (rsp_*): one transaction per visited vertex in depth first order,
//   rsp_last on the final one; rsp_status flags an earlier dropped edge, or a bad
//   start vertex (single result, vertex 0).
//   Config: num_vertices at byte address 0 over the APB-style port; write only idle.
// Timing:
//   A search is paced by the one-read-per-cycle node store and list head memories.
//   The first result is loaded into the output register when the second vertex is
//   found and that register is free, or at the end of the walk.
//   One request is worked at a time; the next is taken as soon as the walk ends, even
//   while the last result still waits in the output register.
// Reset clears all lists, the node count, the overflow flag and sets num_vertices
// to 32. A stalled receiver holds the result and pauses the walk at its next result.
module graph_depth_first_search_unit #(
   parameter int MAX_VERTICES = gdfs_pkg::DEF_MAX_VERTICES,
   parameter int MAX_NODES    = gdfs_pkg::DEF_MAX_NODES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [gdfs_pkg::REQ_W-1:0]         req_type,
   input  logic [gdfs_pkg::VERTEX_W-1:0]      req_src_vertex,
   input  logic [gdfs_pkg::VERTEX_W-1:0]      req_dest_vertex,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [gdfs_pkg::VERTEX_W-1:0]      rsp_visited_vertex,
   output logic                               rsp_last,
   output logic [gdfs_pkg::STATUS_W-1:0]      rsp_status,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [gdfs_pkg::APB_ADDR_W-1:0]    paddr,
   input  logic [gdfs_pkg::APB_DATA_W-1:0]    pwdata,
   output logic [gdfs_pkg::APB_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import gdfs_pkg::*;

   gdfs_cmd_type       cmd;
   gdfs_sts_type       sts;
   logic [COUNT_W-1:0] num_vertices;

   gdfs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .num_vertices (num_vertices)
   );

   gdfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gdfs_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_NODES    (MAX_NODES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .num_vertices       (num_vertices),
      .req_src_vertex     (req_src_vertex),
      .req_dest_vertex    (req_dest_vertex),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_visited_vertex (rsp_visited_vertex),
      .rsp_last           (rsp_last),
      .rsp_status         (rsp_status)
   );

endmodule

// ===== tb/dfs_order_check.sv =====
// Watches the request, result and register ports, predicts the DFS visit order and compares.
module dfs_order_check #(
   parameter int MAX_VERTICES = gdfs_pkg::DEF_MAX_VERTICES,
   parameter int MAX_NODES    = gdfs_pkg::DEF_MAX_NODES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [gdfs_pkg::REQ_W-1:0]         req_type,
   input  logic [gdfs_pkg::VERTEX_W-1:0]      req_src_vertex,
   input  logic [gdfs_pkg::VERTEX_W-1:0]      req_dest_vertex,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [gdfs_pkg::VERTEX_W-1:0]      rsp_visited_vertex,
   input  logic                               rsp_last,
   input  logic [gdfs_pkg::STATUS_W-1:0]      rsp_status,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [gdfs_pkg::APB_ADDR_W-1:0]    paddr,
   input  logic [gdfs_pkg::APB_DATA_W-1:0]    pwdata,
   input  logic                               pready,
   output int                                 mismatch_count,
   output int                                 pending_visits
);
   import gdfs_pkg::*;

   localparam int LINK_W = $clog2(MAX_NODES + 1);

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic                last;
      logic [STATUS_W-1:0] status;
   } visit_type;

   // links hold node index plus one, zero ends a list
   logic [LINK_W-1:0]   head_link    [MAX_VERTICES];
   logic [VERTEX_W-1:0] node_vertex  [MAX_NODES];
   logic [LINK_W-1:0]   node_next    [MAX_NODES];
   logic [LINK_W-1:0]   cursor_stack [MAX_VERTICES];
   bit                  seen         [MAX_VERTICES];
   int unsigned         nodes_taken;
   bit                  edge_dropped;
   logic [COUNT_W-1:0]  vertex_count_reg;
   visit_type           expected_visits [$];
   int                  errors = 0;

   function automatic visit_type make_visit(input logic [VERTEX_W-1:0] vertex, input logic last,
                                            input logic [STATUS_W-1:0] status);
      visit_type item;
      item.vertex = vertex;
      item.last   = last;
      item.status = status;
      return item;
   endfunction

   task automatic link_node(input int unsigned owner, input int unsigned neighbour);
      node_vertex[nodes_taken] = VERTEX_W'(neighbour);
      node_next[nodes_taken]   = head_link[owner];
      head_link[owner]         = LINK_W'(nodes_taken + 1);
      nodes_taken              = nodes_taken + 1;
   endtask

   task automatic walk_from(input logic [VERTEX_W-1:0] start);
      visit_type           walk [$];
      visit_type           item;
      logic [STATUS_W-1:0] status;
      logic [VERTEX_W-1:0] w;
      int unsigned         depth;
      int unsigned         link;
      status = edge_dropped ? STATUS_DROPPED : STATUS_OK;
      for (int i = 0; i < MAX_VERTICES; i++) seen[i] = 1'b0;
      seen[start] = 1'b1;
      walk.push_back(make_visit(start, 1'b0, status));
      cursor_stack[0] = head_link[start];
      depth = 1;
      while (depth > 0) begin
         link = cursor_stack[depth-1];
         if (link == 0 || link > MAX_NODES) begin
            depth = depth - 1;
         end else begin
            cursor_stack[depth-1] = node_next[link-1];
            w = node_vertex[link-1];
            if (!seen[w]) begin
               seen[w] = 1'b1;
               if (walk.size() < MAX_VERTICES) walk.push_back(make_visit(w, 1'b0, status));
               if (depth < MAX_VERTICES) begin
                  cursor_stack[depth] = head_link[w];
                  depth = depth + 1;
               end
            end
         end
      end
      for (int i = 0; i < walk.size(); i++) begin
         item = walk[i];
         item.last = (i == walk.size() - 1);
         expected_visits.push_back(item);
      end
   endtask

   task automatic predict_request(input logic [REQ_W-1:0] kind,
                                  input logic [VERTEX_W-1:0] src,
                                  input logic [VERTEX_W-1:0] dst);
      int unsigned limit;
      limit = (vertex_count_reg > MAX_VERTICES) ? MAX_VERTICES : vertex_count_reg;
      case (kind)
         REQ_CLEAR: begin
            for (int i = 0; i < MAX_VERTICES; i++) head_link[i] = '0;
            nodes_taken  = 0;
            edge_dropped = 1'b0;
         end
         REQ_EDGE: begin
            if (src >= limit || dst >= limit || nodes_taken + 2 > MAX_NODES) begin
               edge_dropped = 1'b1;
            end else begin
               link_node(src, dst);
               link_node(dst, src);
            end
         end
         REQ_SEARCH: begin
            if (src >= limit) expected_visits.push_back(make_visit('0, 1'b1, STATUS_BAD_START));
            else walk_from(src);
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      visit_type want;
      if (reset) begin
         for (int i = 0; i < MAX_VERTICES; i++) head_link[i] = '0;
         nodes_taken      = 0;
         edge_dropped     = 1'b0;
         vertex_count_reg = NUM_VERTICES_RESET;
         expected_visits.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_visits.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %0d last %0d status %0d",
                        $time, rsp_visited_vertex, rsp_last, rsp_status);
               errors++;
            end else begin
               want = expected_visits.pop_front();
               check_field("visited_vertex", want.vertex, rsp_visited_vertex);
               check_field("last", want.last, rsp_last);
               check_field("status", want.status, rsp_status);
            end
         end
         if (req_valid && !req_stall) predict_request(req_type, req_src_vertex, req_dest_vertex);
         if (psel && penable && pwrite && pready && paddr[2] == REG_NUM_VERTICES)
            vertex_count_reg = pwdata[COUNT_W-1:0];
      end
      mismatch_count <= errors;
      pending_visits <= expected_visits.size();
   end

endmodule

// ===== tb/tb_graph_depth_first_search_unit.sv =====
// Stimulus and verdict for the graph depth first search unit.
module tb_graph_depth_first_search_unit;
   import gdfs_pkg::*;

   localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int DRAIN_CYCLES    = 400;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int FILL_EDGES      = 80;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [REQ_W-1:0]      req_type;
   logic [VERTEX_W-1:0]   req_src_vertex;
   logic [VERTEX_W-1:0]   req_dest_vertex;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [VERTEX_W-1:0]   rsp_visited_vertex;
   logic                  rsp_last;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [APB_ADDR_W-1:0] paddr;
   logic [APB_DATA_W-1:0] pwdata;
   logic [APB_DATA_W-1:0] prdata;
   logic                  pready;

   int mismatch_count;
   int pending_visits;
   int cycle_count = 0;
   bit sender_gaps;
   bit receiver_gaps;
   bit hold_off_request;
   bit hold_off_done;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   graph_depth_first_search_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_src_vertex     (req_src_vertex),
      .req_dest_vertex    (req_dest_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_visited_vertex (rsp_visited_vertex),
      .rsp_last           (rsp_last),
      .rsp_status         (rsp_status),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   dfs_order_check i_order_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_src_vertex     (req_src_vertex),
      .req_dest_vertex    (req_dest_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_visited_vertex (rsp_visited_vertex),
      .rsp_last           (rsp_last),
      .rsp_status         (rsp_status),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .pready             (pready),
      .mismatch_count     (mismatch_count),
      .pending_visits     (pending_visits)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [VERTEX_W-1:0] src,
                               input logic [VERTEX_W-1:0] dst);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 9) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_src_vertex  <= src;
      req_dest_vertex <= dst;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic random_request(input int unsigned count);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 4)
         send_request(REQ_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom));
      else if (pick < 8)
         send_request(REQ_RESERVED, VERTEX_W'($urandom), VERTEX_W'($urandom));
      else if (pick < 60)
         send_request(REQ_EDGE, VERTEX_W'($urandom_range(0, count - 1)),
                      VERTEX_W'($urandom_range(0, count - 1)));
      else if (pick < 68)
         send_request(REQ_EDGE, VERTEX_W'($urandom), VERTEX_W'($urandom));
      else if (pick < 92)
         send_request(REQ_SEARCH, VERTEX_W'($urandom_range(0, count - 1)), VERTEX_W'($urandom));
      else
         send_request(REQ_SEARCH, VERTEX_W'($urandom), VERTEX_W'($urandom));
   endtask

   // an edge may still be in flight after the last result, hence the extra cycles
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_visits != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_vertex_count(input logic [COUNT_W-1:0] count);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_NUM_VERTICES, 2'b00};
      pwdata  <= ($urandom() & ~32'h3F) | APB_DATA_W'(count);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin : receiver
      int wait_cycles;
      rsp_stall     = 1'b0;
      hold_off_done = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_request && !hold_off_done) begin
            hold_off_done = 1'b1;
            wait_cycles = HOLD_OFF_CYCLES;
         end else begin
            wait_cycles = receiver_gaps ? $urandom_range(0, 9) : 0;
         end
         if (wait_cycles > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (wait_cycles - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin : stimulus
      int unsigned count;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = REQ_CLEAR;
      req_src_vertex   = '0;
      req_dest_vertex  = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      sender_gaps      = 1'b1;
      receiver_gaps    = 1'b1;
      hold_off_request = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty graph, small cycle, self loop, top vertices, reserved code
      send_request(REQ_SEARCH, 5'd0, 5'd0);
      send_request(REQ_EDGE, 5'd0, 5'd1);
      send_request(REQ_EDGE, 5'd1, 5'd2);
      send_request(REQ_EDGE, 5'd0, 5'd2);
      send_request(REQ_EDGE, 5'd2, 5'd3);
      send_request(REQ_EDGE, 5'd3, 5'd3);
      send_request(REQ_EDGE, 5'd31, 5'd30);
      send_request(REQ_RESERVED, 5'd31, 5'd31);
      send_request(REQ_SEARCH, 5'd0, 5'd31);
      send_request(REQ_SEARCH, 5'd31, 5'd0);
      send_request(REQ_SEARCH, 5'd29, 5'd0);
      drain_results();
      // endpoints out of range, sticky drop flag, bad start vertex
      write_vertex_count(6'd4);
      send_request(REQ_EDGE, 5'd4, 5'd1);
      send_request(REQ_EDGE, 5'd1, 5'd31);
      send_request(REQ_SEARCH, 5'd0, 5'd0);
      send_request(REQ_SEARCH, 5'd4, 5'd0);
      send_request(REQ_SEARCH, 5'd31, 5'd0);
      drain_results();
      write_vertex_count(6'd1);
      send_request(REQ_CLEAR, 5'd0, 5'd0);
      send_request(REQ_EDGE, 5'd0, 5'd0);
      send_request(REQ_SEARCH, 5'd0, 5'd0);
      send_request(REQ_SEARCH, 5'd1, 5'd0);
      drain_results();
      write_vertex_count(6'd32);
      send_request(REQ_CLEAR, 5'd31, 5'd31);
      send_request(REQ_SEARCH, 5'd31, 5'd0);
      drain_results();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: count = 32;
            1: count = 8;
            2: count = 2;
            3: count = $urandom_range(3, 31);
            4: count = 1;
            default: count = 32;
         endcase
         write_vertex_count(COUNT_W'(count));
         sender_gaps   = (phase != 2);
         receiver_gaps = (phase != 2);
         send_request(REQ_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom));
         if (phase == 1) hold_off_request = 1'b1;
         if (phase == 5) begin
            // run the node store past full, searching a dense graph along the way
            for (int i = 0; i < FILL_EDGES; i++) begin
               if (i % 10 == 9)
                  send_request(REQ_SEARCH, VERTEX_W'($urandom), VERTEX_W'($urandom));
               else
                  send_request(REQ_EDGE, VERTEX_W'($urandom), VERTEX_W'($urandom));
            end
            repeat (4) send_request(REQ_SEARCH, VERTEX_W'($urandom), VERTEX_W'($urandom));
         end else begin
            repeat (20) random_request(count);
         end
         drain_results();
      end

      if (mismatch_count == 0 && pending_visits == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
